// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold on every rising clock edge outside reset.
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_AT(name, clk, rst_n, prop, msg)
`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/ewalu_pkg.sv
package ewalu_pkg;

  // Operation codes; code 31 is unused and acts as a no-op.
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_ADD16 = 5'd10,
    OP_ADDSP = 5'd11,
    OP_RLC   = 5'd12,
    OP_RRC   = 5'd13,
    OP_RL    = 5'd14,
    OP_RR    = 5'd15,
    OP_SLA   = 5'd16,
    OP_SRA   = 5'd17,
    OP_SWAP  = 5'd18,
    OP_SRL   = 5'd19,
    OP_BIT   = 5'd20,
    OP_RES   = 5'd21,
    OP_SET   = 5'd22,
    OP_DAA   = 5'd23,
    OP_RLCA  = 5'd24,
    OP_RRCA  = 5'd25,
    OP_RLA   = 5'd26,
    OP_RRA   = 5'd27,
    OP_CPL   = 5'd28,
    OP_SCF   = 5'd29,
    OP_CCF   = 5'd30
  } op_e;

  // Flag bit positions.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [3:0] BCD_MAX   = 4'h9;

  localparam int unsigned REQ_W      = 60;
  localparam int unsigned REQ_DATA_W = 64;
  localparam int unsigned RSP_W      = 20;
  localparam int unsigned RSP_DATA_W = 24;

  // Packed with the first field in the highest bits.
  typedef struct packed {
    logic [3:0]  flags_in;
    logic [2:0]  bit_index;
    logic [15:0] wide_addend;
    logic [15:0] wide_base;
    logic [7:0]  operand;
    logic [7:0]  acc;
    logic [4:0]  operation;
  } req_t;

  typedef struct packed {
    logic [3:0]  flags_out;
    logic [15:0] result;
  } rsp_t;

endpackage

// File: rtl/ewalu_core.sv
module ewalu_core (
  input  ewalu_pkg::req_t req_i,
  output ewalu_pkg::rsp_t rsp_o
);

  function automatic logic is_zero(input logic [7:0] val);
    return (val == 8'h00);
  endfunction

  logic [7:0]  a;
  logic [7:0]  v;
  logic [3:0]  f;
  logic        cin;
  logic        c_add;
  logic        c_sub;
  logic [8:0]  add9;
  logic [4:0]  addh;
  logic [8:0]  sub9;
  logic [4:0]  subh;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [16:0] w17;
  logic [12:0] w13;
  logic [15:0] sp16;
  logic [8:0]  sp9;
  logic [4:0]  sph;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_t;
  logic        daa_c;
  logic [7:0]  r8;
  logic [15:0] res;
  logic [3:0]  nf;
  ewalu_pkg::op_e op;

  assign op    = ewalu_pkg::op_e'(req_i.operation);
  assign a     = req_i.acc;
  assign v     = req_i.operand;
  assign f     = req_i.flags_in;
  assign cin   = f[ewalu_pkg::FLAG_C];
  assign c_add = (op == ewalu_pkg::OP_ADC) && cin;
  assign c_sub = (op == ewalu_pkg::OP_SBC) && cin;

  assign add9 = {1'b0, a} + {1'b0, v} + {8'd0, c_add};
  assign addh = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c_add};
  // Borrow shows up as the sign bit of the 9-bit difference.
  assign sub9 = {1'b0, a} - {1'b0, v} - {8'd0, c_sub};
  assign subh = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c_sub};
  assign inc8 = a + 8'd1;
  assign dec8 = a - 8'd1;

  assign w17  = {1'b0, req_i.wide_base} + {1'b0, req_i.wide_addend};
  assign w13  = {1'b0, req_i.wide_base[11:0]} + {1'b0, req_i.wide_addend[11:0]};
  assign sp16 = req_i.wide_base + {{8{v[7]}}, v};
  assign sp9  = {1'b0, req_i.wide_base[7:0]} + {1'b0, v};
  assign sph  = {1'b0, req_i.wide_base[3:0]} + {1'b0, v[3:0]};

  assign bit_mask = 8'h01 << req_i.bit_index;

  always_comb begin
    daa_t = a;
    daa_c = cin;
    if (!f[ewalu_pkg::FLAG_N]) begin
      if (daa_c || (a > ewalu_pkg::DAA_LIMIT)) begin
        daa_t = a + ewalu_pkg::DAA_HI;
        daa_c = 1'b1;
      end
      if (f[ewalu_pkg::FLAG_H] || (daa_t[3:0] > ewalu_pkg::BCD_MAX)) begin
        daa_t = daa_t + ewalu_pkg::DAA_LO;
      end
    end else begin
      if (daa_c) begin
        daa_t = daa_t - ewalu_pkg::DAA_HI;
      end
      if (f[ewalu_pkg::FLAG_H]) begin
        daa_t = daa_t - ewalu_pkg::DAA_LO;
      end
    end
  end

  always_comb begin
    r8  = a;
    res = {8'h00, a};
    nf  = f;
    case (op)
      ewalu_pkg::OP_ADD, ewalu_pkg::OP_ADC: begin
        r8  = add9[7:0];
        res = {8'h00, r8};
        nf  = {is_zero(r8), 1'b0, addh[4], add9[8]};
      end
      ewalu_pkg::OP_SUB, ewalu_pkg::OP_SBC, ewalu_pkg::OP_CP: begin
        r8  = sub9[7:0];
        res = (op == ewalu_pkg::OP_CP) ? {8'h00, a} : {8'h00, r8};
        nf  = {is_zero(r8), 1'b1, subh[4], sub9[8]};
      end
      ewalu_pkg::OP_AND: begin
        r8  = a & v;
        res = {8'h00, r8};
        nf  = {is_zero(r8), 1'b0, 1'b1, 1'b0};
      end
      ewalu_pkg::OP_XOR: begin
        r8  = a ^ v;
        res = {8'h00, r8};
        nf  = {is_zero(r8), 3'b000};
      end
      ewalu_pkg::OP_OR: begin
        r8  = a | v;
        res = {8'h00, r8};
        nf  = {is_zero(r8), 3'b000};
      end
      ewalu_pkg::OP_INC: begin
        res = {8'h00, inc8};
        nf  = {is_zero(inc8), 1'b0, (a[3:0] == 4'hF), cin};
      end
      ewalu_pkg::OP_DEC: begin
        res = {8'h00, dec8};
        nf  = {is_zero(dec8), 1'b1, (a[3:0] == 4'h0), cin};
      end
      ewalu_pkg::OP_ADD16: begin
        res = w17[15:0];
        nf  = {f[ewalu_pkg::FLAG_Z], 1'b0, w13[12], w17[16]};
      end
      ewalu_pkg::OP_ADDSP: begin
        res = sp16;
        nf  = {2'b00, sph[4], sp9[8]};
      end
      ewalu_pkg::OP_RLC, ewalu_pkg::OP_RLCA: begin
        r8  = {a[6:0], a[7]};
        res = {8'h00, r8};
        nf  = {(op == ewalu_pkg::OP_RLC) && is_zero(r8), 2'b00, a[7]};
      end
      ewalu_pkg::OP_RRC, ewalu_pkg::OP_RRCA: begin
        r8  = {a[0], a[7:1]};
        res = {8'h00, r8};
        nf  = {(op == ewalu_pkg::OP_RRC) && is_zero(r8), 2'b00, a[0]};
      end
      ewalu_pkg::OP_RL, ewalu_pkg::OP_RLA: begin
        r8  = {a[6:0], cin};
        res = {8'h00, r8};
        nf  = {(op == ewalu_pkg::OP_RL) && is_zero(r8), 2'b00, a[7]};
      end
      ewalu_pkg::OP_RR, ewalu_pkg::OP_RRA: begin
        r8  = {cin, a[7:1]};
        res = {8'h00, r8};
        nf  = {(op == ewalu_pkg::OP_RR) && is_zero(r8), 2'b00, a[0]};
      end
      ewalu_pkg::OP_SLA: begin
        r8  = {a[6:0], 1'b0};
        res = {8'h00, r8};
        nf  = {is_zero(r8), 2'b00, a[7]};
      end
      ewalu_pkg::OP_SRA: begin
        r8  = {a[7], a[7:1]};
        res = {8'h00, r8};
        nf  = {is_zero(r8), 2'b00, a[0]};
      end
      ewalu_pkg::OP_SWAP: begin
        r8  = {a[3:0], a[7:4]};
        res = {8'h00, r8};
        nf  = {is_zero(r8), 3'b000};
      end
      ewalu_pkg::OP_SRL: begin
        r8  = {1'b0, a[7:1]};
        res = {8'h00, r8};
        nf  = {is_zero(r8), 2'b00, a[0]};
      end
      ewalu_pkg::OP_BIT: begin
        nf = {((a & bit_mask) == 8'h00), 1'b0, 1'b1, cin};
      end
      ewalu_pkg::OP_RES: begin
        res = {8'h00, a & ~bit_mask};
      end
      ewalu_pkg::OP_SET: begin
        res = {8'h00, a | bit_mask};
      end
      ewalu_pkg::OP_DAA: begin
        res = {8'h00, daa_t};
        nf  = {is_zero(daa_t), f[ewalu_pkg::FLAG_N], 1'b0, daa_c};
      end
      ewalu_pkg::OP_CPL: begin
        res = {8'h00, ~a};
        nf  = {f[ewalu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
      end
      ewalu_pkg::OP_SCF: begin
        nf = {f[ewalu_pkg::FLAG_Z], 2'b00, 1'b1};
      end
      ewalu_pkg::OP_CCF: begin
        nf = {f[ewalu_pkg::FLAG_Z], 2'b00, ~cin};
      end
      default: begin
        res = {8'h00, a};
        nf  = f;
      end
    endcase
  end

  assign rsp_o.result    = res;
  assign rsp_o.flags_out = nf;

endmodule

// File: rtl/eight_bit_alu_with_flags.sv
// Channel  | Dir | Handshake             | Payload
// ---------+-----+-----------------------+------------------------------------------
// s_axis   | in  | s_axis_tvalid/tready  | one request: operation, operands, flags
// m_axis   | out | m_axis_tvalid/tready  | one result: 16-bit value and new flags
//
// One request per clock sustained while m_axis_tready stays high; a request passes
// through the request register, ALU logic and result register.
// Reset (rst_ni low, async) empties both stages; payload registers are not reset.
// A stalled result holds in the output register while the request stage still
// takes a new request; s_axis_tready drops only when both stages are full.
`include "assert_macros.svh"

module eight_bit_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] operation, [12:5] acc, [20:13] operand, [36:21] wide_base,
  // [52:37] wide_addend, [55:53] bit_index, [59:56] flags_in, [63:60] unused
  input  logic [63:0] s_axis_tdata,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] result, [19:16] flags_out, [23:20] zero
  output logic [23:0] m_axis_tdata
);

  // Request stage
  ewalu_pkg::req_t req_q;
  logic            req_valid_q;
  logic            req_valid_d;

  // Result stage
  ewalu_pkg::rsp_t rsp_d;
  ewalu_pkg::rsp_t rsp_q;
  logic            rsp_valid_q;
  logic            rsp_valid_d;

  logic            in_hs;
  logic            advance;

  // The request stage can move on when the result register is empty or draining.
  assign advance       = !rsp_valid_q || m_axis_tready;
  assign s_axis_tready = !req_valid_q || advance;
  assign in_hs         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_hs) begin
      req_valid_d = 1'b1;
    end else if (advance) begin
      req_valid_d = 1'b0;
    end
  end

  assign rsp_valid_d = advance ? req_valid_q : rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      req_q <= ewalu_pkg::req_t'(s_axis_tdata[ewalu_pkg::REQ_W-1:0]);
    end
    if (advance && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  ewalu_core u_core (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  assign m_axis_tvalid = rsp_valid_q;
  assign m_axis_tdata  = {{(ewalu_pkg::RSP_DATA_W - ewalu_pkg::RSP_W){1'b0}}, rsp_q};

  // A result only appears after a request sat in the request stage.
  `ASSERT_AT(a_out_from_req, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(req_valid_q), "result without request")
  // A blocked output must keep the pending request.
  `ASSERT_AT(a_hold_req, clk_i, rst_ni, (rsp_valid_q && !m_axis_tready && req_valid_q) |=> req_valid_q, "request lost under stall")
  // Backpressure on the input only when both stages are occupied.
  `ASSERT_NEVER(a_ready_full, clk_i, rst_ni, !s_axis_tready && !(req_valid_q && rsp_valid_q), "input stalled with room")

endmodule
